>>> hw/rtl/ucfp_pkg.sv
// Shared types, constants and character tables of the command frame parser.
`timescale 1ns / 1ps
`default_nettype none
package ucfp_pkg;

   // Frame and device limits
   localparam int FRAME_BYTES  = 30;
   localparam int MOSFET_COUNT = 12;
   localparam int SERVO_COUNT  = 3;
   localparam int HEATER_COUNT = 3;
   localparam int POS_W        = $clog2(FRAME_BYTES + 1);

   // Identifier candidates
   localparam int ID_COUNT = 5;
   localparam int ID_DEPTH = 16;
   localparam int ID_MOSFET = 0;
   localparam int ID_SERVO  = 1;
   localparam int ID_AUTO   = 2;
   localparam int ID_HEATER = 3;
   localparam int ID_LED    = 4;
   localparam int DOLLAR_BIT = 5;

   // Characters
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_W      = 8'h57;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;

   localparam logic [3:0] ID_LEN [ID_COUNT] = '{4'd7, 4'd6, 4'd13, 4'd11, 4'd4};

   localparam logic [7:0] ID_TEXT [ID_COUNT][ID_DEPTH] = '{
      '{0:"$", 1:"M", 2:"O", 3:"S", 4:"F", 5:"E", 6:"T", default:8'h00},
      '{0:"$", 1:"S", 2:"E", 3:"R", 4:"V", 5:"O", default:8'h00},
      '{0:"$", 1:"A", 2:"U", 3:"T", 4:"O", 5:"_", 6:"S", 7:"H", 8:"U", 9:"T",
        10:"O", 11:"F", 12:"F", default:8'h00},
      '{0:"$", 1:"H", 2:"E", 3:"A", 4:"T", 5:"E", 6:"R", 7:"_", 8:"C", 9:"M",
        10:"D", default:8'h00},
      '{0:"$", 1:"L", 2:"E", 3:"D", default:8'h00}
   };

   // Input item kind
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // Field parse phases
   typedef enum logic [2:0] {
      PH_SKIP     = 3'd0,
      PH_SIGN_POS = 3'd1,
      PH_SIGN_NEG = 3'd2,
      PH_DIG_POS  = 3'd3,
      PH_DIG_NEG  = 3'd4,
      PH_DONE     = 3'd5,
      PH_BETWEEN  = 3'd6,
      PH_ENDED    = 3'd7
   } phase_type;

   // Action codes
   typedef enum logic [2:0] {
      ACT_NONE   = 3'd0,
      ACT_MOSFET = 3'd1,
      ACT_SERVO  = 3'd2,
      ACT_AUTO   = 3'd3,
      ACT_HEATER = 3'd4,
      ACT_LED    = 3'd5,
      ACT_KICK   = 3'd6
   } action_type;

   // Result of one frame step
   typedef struct packed {
      action_type         action;
      logic [3:0]         device_index;
      logic signed [15:0] action_value;
   } result_type;

endpackage
`default_nettype wire

>>> hw/rtl/uart_command_frame_parser_unit.sv
// Top level of the UART command frame parser: input and result registers.
`timescale 1ns / 1ps
`default_nettype none
// Each transaction on req is either a received UART byte (req_tuser = 0) or a
// one millisecond tick (req_tuser = 1) and yields exactly one rsp transaction.
// A '$' restarts a 30-byte frame; when its last byte arrives the response
// carries the parsed action, otherwise action is none. The response always
// reports the current watchdog flag. The block takes one transaction per
// cycle while rsp_tready stays high: an input register feeds combinational
// parse and dispatch logic into the result register. The watchdog timeout
// may be written through csr_we/csr_wdata while no transaction is in flight.
module uart_command_frame_parser_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  wire logic        req_tuser,   // [0] command
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [2:0] action, [6:3] device_index,
                                         // [22:7] action_value, [23] watchdog_flag
   input  wire logic        csr_we,
   input  wire logic [15:0] csr_wdata
);

   logic                 in_vld_ff;
   logic                 in_cmd_ff;
   logic [7:0]           in_byte_ff;
   logic                 out_vld_ff;
   logic [23:0]          out_data_ff;
   logic                 advance;
   logic                 kick;
   logic                 lost_in;
   ucfp_pkg::result_type result;

   // Move the held transaction on when the result register frees up
   assign advance    = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;

   ucfp_frame u_frame (
      .clock   (clock),
      .reset   (reset),
      .step    (advance && in_cmd_ff == ucfp_pkg::CMD_BYTE),
      .rx_byte (in_byte_ff),
      .result  (result),
      .kick    (kick)
   );

   ucfp_watchdog u_watchdog (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .tick      (advance && in_cmd_ff == ucfp_pkg::CMD_TICK),
      .kick      (advance && in_cmd_ff == ucfp_pkg::CMD_BYTE && kick),
      .lost_in   (lost_in)
   );

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_cmd_ff  <= req_tuser;
         in_byte_ff <= req_tdata;
      end
   end

   // Result register; ticks report no action
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_vld_ff <= 1'b0;
      end
      if (advance) begin
         if (in_cmd_ff == ucfp_pkg::CMD_TICK) begin
            out_data_ff <= {lost_in, 16'd0, 4'd0, ucfp_pkg::ACT_NONE};
         end else begin
            out_data_ff <= {lost_in, result.action_value, result.device_index,
                            result.action};
         end
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;

endmodule
`default_nettype wire

>>> hw/rtl/ucfp_frame.sv
// Frame tracker, incremental token parser and end-of-frame dispatch.
`timescale 1ns / 1ps
`default_nettype none
module ucfp_frame (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,      // take one byte this cycle
   input  wire logic [7:0]           rx_byte,
   output ucfp_pkg::result_type      result,
   output logic                      kick
);

   logic [ucfp_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [1:0]                 tok_ff, tok_in;
   logic [5:0]                 match_ff, match_in;
   logic signed [15:0]         f1_ff, f1_in, f2_ff, f2_in;
   ucfp_pkg::phase_type        ph_ff, ph_in;
   logic [7:0]                 sb_ff, sb_in;

   // Multiply by ten and add or subtract a digit, saturating to 16 bits
   function automatic logic signed [15:0] add_digit(input logic signed [15:0] v,
                                                    input logic [3:0] d,
                                                    input logic neg);
      logic signed [20:0] ext;
      logic signed [20:0] t10;
      logic signed [20:0] dd;
      logic signed [20:0] nv;
      begin
         ext = 21'(v);
         t10 = (ext <<< 3) + (ext <<< 1);
         dd  = $signed({17'd0, d});
         if (neg) begin
            nv = t10 - dd;
            if (nv < -21'sd32768) nv = -21'sd32768;
         end else begin
            nv = t10 + dd;
            if (nv > 21'sd32767) nv = 21'sd32767;
         end
         add_digit = nv[15:0];
      end
   endfunction

   // Next frame state and dispatch decision
   always_comb begin
      logic [ucfp_pkg::POS_W-1:0] p;
      logic [1:0]                 t;
      ucfp_pkg::phase_type        phl;
      logic                       is_space, is_digit, neg, dispatch;
      logic [4:0]                 m;
      logic signed [15:0]         a, s;

      pos_in   = pos_ff;
      tok_in   = tok_ff;
      match_in = match_ff;
      f1_in    = f1_ff;
      f2_in    = f2_ff;
      ph_in    = ph_ff;
      sb_in    = sb_ff;
      dispatch = 1'b0;
      t        = 2'd0;
      phl      = ucfp_pkg::PH_SKIP;
      neg      = 1'b0;
      m        = 5'd0;
      a        = '0;
      s        = '0;
      result   = '{action: ucfp_pkg::ACT_NONE, device_index: 4'd0, action_value: 16'sd0};
      kick     = 1'b0;
      is_space = (rx_byte == ucfp_pkg::CH_SPACE) ||
                 (rx_byte >= ucfp_pkg::CH_TAB && rx_byte <= ucfp_pkg::CH_CR);
      is_digit = (rx_byte >= ucfp_pkg::CH_ZERO && rx_byte <= ucfp_pkg::CH_NINE);

      // restart the frame on a dollar sign
      if (rx_byte == ucfp_pkg::CH_DOLLAR) begin
         pos_in   = '0;
         tok_in   = 2'd0;
         match_in = 6'b011111;
         f1_in    = '0;
         f2_in    = '0;
         ph_in    = ucfp_pkg::PH_SKIP;
         sb_in    = 8'd0;
      end
      p = pos_in;

      if (pos_in != ucfp_pkg::POS_W'(ucfp_pkg::FRAME_BYTES)) begin
         if (p == ucfp_pkg::POS_W'(1)) sb_in = rx_byte;

         if (ph_in == ucfp_pkg::PH_ENDED) begin
            // string already ended: count only
         end else if (tok_in == 2'd0 && ph_in != ucfp_pkg::PH_BETWEEN) begin
            // identifier token
            if (rx_byte == ucfp_pkg::CH_COMMA || rx_byte == ucfp_pkg::CH_NUL) begin
               for (int i = 0; i < ucfp_pkg::ID_COUNT; i++)
                  if (ucfp_pkg::POS_W'(ucfp_pkg::ID_LEN[i]) != p) match_in[i] = 1'b0;
               ph_in = (rx_byte == ucfp_pkg::CH_NUL) ? ucfp_pkg::PH_ENDED
                                                     : ucfp_pkg::PH_BETWEEN;
            end else begin
               for (int i = 0; i < ucfp_pkg::ID_COUNT; i++)
                  if (!(p < ucfp_pkg::POS_W'(ucfp_pkg::ID_LEN[i]) &&
                        rx_byte == ucfp_pkg::ID_TEXT[i][p[3:0]]))
                     match_in[i] = 1'b0;
               if (p == '0 && rx_byte == ucfp_pkg::CH_DOLLAR)
                  match_in[ucfp_pkg::DOLLAR_BIT] = 1'b1;
            end
         end else if (rx_byte == ucfp_pkg::CH_NUL) begin
            ph_in = ucfp_pkg::PH_ENDED;
         end else if (rx_byte == ucfp_pkg::CH_COMMA) begin
            ph_in = ucfp_pkg::PH_BETWEEN;
         end else begin
            // numeric field
            t   = tok_in;
            phl = ph_in;
            if (ph_in == ucfp_pkg::PH_BETWEEN) begin
               if (t != 2'd3) t = t + 2'd1;
               phl = ucfp_pkg::PH_SKIP;
            end
            tok_in = t;
            ph_in  = phl;
            if (phl == ucfp_pkg::PH_SKIP && is_space) begin
               ph_in = ucfp_pkg::PH_SKIP;
            end else if (phl == ucfp_pkg::PH_SKIP && rx_byte == ucfp_pkg::CH_PLUS) begin
               ph_in = ucfp_pkg::PH_SIGN_POS;
            end else if (phl == ucfp_pkg::PH_SKIP && rx_byte == ucfp_pkg::CH_MINUS) begin
               ph_in = ucfp_pkg::PH_SIGN_NEG;
            end else if (phl == ucfp_pkg::PH_DONE || !is_digit) begin
               ph_in = ucfp_pkg::PH_DONE;
            end else begin
               neg   = (phl == ucfp_pkg::PH_SIGN_NEG || phl == ucfp_pkg::PH_DIG_NEG);
               ph_in = neg ? ucfp_pkg::PH_DIG_NEG : ucfp_pkg::PH_DIG_POS;
               if (t == 2'd1) f1_in = add_digit(f1_in, rx_byte[3:0], neg);
               if (t == 2'd2) f2_in = add_digit(f2_in, rx_byte[3:0], neg);
            end
         end

         pos_in   = p + ucfp_pkg::POS_W'(1);
         dispatch = (pos_in == ucfp_pkg::POS_W'(ucfp_pkg::FRAME_BYTES));
      end

      // pick the action once the frame is full
      a = f1_in;
      s = f2_in;
      m = match_in[4:0];
      if (tok_in == 2'd0 && ph_in != ucfp_pkg::PH_BETWEEN && ph_in != ucfp_pkg::PH_ENDED)
         m = 5'd0;
      if (dispatch && match_in[ucfp_pkg::DOLLAR_BIT]) begin
         if (sb_in == ucfp_pkg::CH_W) begin
            kick          = 1'b1;
            result.action = ucfp_pkg::ACT_KICK;
         end else if (m[ucfp_pkg::ID_MOSFET] && tok_in >= 2'd2 && !a[15] &&
                      a < 16'(ucfp_pkg::MOSFET_COUNT)) begin
            result.action       = ucfp_pkg::ACT_MOSFET;
            result.device_index = a[3:0];
            result.action_value = {15'd0, (s != 16'sd0)};
         end else if (m[ucfp_pkg::ID_SERVO] && tok_in >= 2'd2 && !a[15] &&
                      a < 16'(ucfp_pkg::SERVO_COUNT)) begin
            result.action       = ucfp_pkg::ACT_SERVO;
            result.device_index = a[3:0];
            result.action_value = s;
         end else if (m[ucfp_pkg::ID_AUTO] && tok_in >= 2'd1) begin
            result.action       = ucfp_pkg::ACT_AUTO;
            result.action_value = {15'd0, (a != 16'sd0)};
         end else if (m[ucfp_pkg::ID_HEATER] && tok_in >= 2'd2 && !a[15] &&
                      a < 16'(ucfp_pkg::HEATER_COUNT)) begin
            result.action       = ucfp_pkg::ACT_HEATER;
            result.device_index = a[3:0];
            result.action_value = {15'd0, (s != 16'sd0)};
         end else if (m[ucfp_pkg::ID_LED] && tok_in >= 2'd1 && !a[15] && a < 16'sd4) begin
            result.action       = ucfp_pkg::ACT_LED;
            result.action_value = a;
         end
      end
   end

   // Hold frame state; advance on each byte taken
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         tok_ff   <= 2'd0;
         match_ff <= 6'b011111;
         f1_ff    <= '0;
         f2_ff    <= '0;
         ph_ff    <= ucfp_pkg::PH_SKIP;
         sb_ff    <= 8'd0;
      end else if (step) begin
         pos_ff   <= pos_in;
         tok_ff   <= tok_in;
         match_ff <= match_in;
         f1_ff    <= f1_in;
         f2_ff    <= f2_in;
         ph_ff    <= ph_in;
         sb_ff    <= sb_in;
      end
   end

endmodule
`default_nettype wire

>>> hw/rtl/ucfp_watchdog.sv
// Link watchdog: tick counter, timeout register and expiry flag.
`timescale 1ns / 1ps
`default_nettype none
module ucfp_watchdog (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [15:0] csr_wdata,
   input  wire logic        tick,      // one millisecond tick this cycle
   input  wire logic        kick,      // watchdog frame dispatched this cycle
   output logic             lost_in    // flag value after this step
);

   logic [15:0] timeout_ff;
   logic [15:0] count_ff, count_in;
   logic        lost_ff;

   // Count ticks, expire on timeout, clear on kick
   always_comb begin
      count_in = count_ff;
      lost_in  = lost_ff;
      if (tick) begin
         count_in = count_ff + 16'd1;
         if (count_in >= timeout_ff) begin
            count_in = 16'd0;
            lost_in  = 1'b1;
         end
      end else if (kick) begin
         count_in = 16'd0;
         lost_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= 16'd1000;
         count_ff   <= 16'd0;
         lost_ff    <= 1'b0;
      end else begin
         if (csr_we) timeout_ff <= csr_wdata;
         count_ff <= count_in;
         lost_ff  <= lost_in;
      end
   end

endmodule
`default_nettype wire
